/* hdl/im2col_address_walker_macros.svh */
// Assertion macros for the im2col address walker.
// Both forms expect aclk in the scope of the user; IAW_ASSERT also expects aresetn.
`ifndef IM2COL_ADDRESS_WALKER_MACROS_SVH
`define IM2COL_ADDRESS_WALKER_MACROS_SVH

`ifndef SYNTHESIS

// checked on every rising edge outside reset
`define IAW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every rising edge, reset included
`define IAW_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`else

`define IAW_ASSERT(label, prop, msg)
`define IAW_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

/* hdl/im2col_pkg.sv */
package im2col_pkg;

    // width of the address fields on the result stream
    localparam int OUT_ADDR_W = 24;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PADDING     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_SIZE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SIZE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IN_CHANNELS = 3'd5;

    // register reset values
    localparam logic [15:0] KERNEL_SIZE_RST = 16'd771;
    localparam logic [15:0] STRIDE_RST      = 16'd257;
    localparam logic [11:0] IN_CHANNELS_RST = 12'd1;

    // decoded kernel geometry shared by the walker and the datapath
    typedef struct packed {
        logic [7:0]  kw;
        logic [7:0]  kh;
        logic [7:0]  sw;
        logic [7:0]  sv;
        logic [7:0]  pw;
        logic [7:0]  pv;
        logic [11:0] channels;
    } kern_cfg_t;

endpackage

/* hdl/im2col_walk.sv */
`include "im2col_address_walker_macros.svh"

module im2col_walk
    import im2col_pkg::*;
#(
    parameter int ADDR_BITS = 24,
    parameter int DIM_BITS  = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic                 restart,
    input  kern_cfg_t            kcfg,
    input  logic [DIM_BITS-1:0]  out_w,
    input  logic [DIM_BITS-1:0]  out_h,
    output logic [11:0]          cur_plane,
    output logic [7:0]           cur_kr,
    output logic [7:0]           cur_kc,
    output logic [DIM_BITS-1:0]  cur_orow,
    output logic [DIM_BITS-1:0]  cur_ocol,
    output logic [ADDR_BITS-1:0] cur_dst,
    output logic                 cur_last
);

    logic [11:0]          plane_reg, plane_next;
    logic [7:0]           kr_reg, kr_next;
    logic [7:0]           kc_reg, kc_next;
    logic [DIM_BITS-1:0]  orow_reg, orow_next;
    logic [DIM_BITS-1:0]  ocol_reg, ocol_next;
    logic [ADDR_BITS-1:0] dst_reg, dst_next;

    logic [11:0]         ch_lim;
    logic [7:0]          kh_lim, kw_lim;
    logic [DIM_BITS-1:0] oh_lim, ow_lim;
    logic wrap_oc, wrap_or, wrap_kc, wrap_kr, wrap_pl;

    // limits: a zero count behaves as one
    assign ch_lim = (kcfg.channels == '0) ? '0 : kcfg.channels - 12'd1;
    assign kh_lim = (kcfg.kh == '0) ? '0 : kcfg.kh - 8'd1;
    assign kw_lim = (kcfg.kw == '0) ? '0 : kcfg.kw - 8'd1;
    assign oh_lim = (out_h == '0) ? '0 : out_h - DIM_BITS'(1);
    assign ow_lim = (out_w == '0) ? '0 : out_w - DIM_BITS'(1);

    // position of this word: restart forces the first element
    assign cur_plane = restart ? '0 : plane_reg;
    assign cur_kr    = restart ? '0 : kr_reg;
    assign cur_kc    = restart ? '0 : kc_reg;
    assign cur_orow  = restart ? '0 : orow_reg;
    assign cur_ocol  = restart ? '0 : ocol_reg;
    assign cur_dst   = restart ? '0 : dst_reg;

    assign wrap_oc = cur_ocol  >= ow_lim;
    assign wrap_or = cur_orow  >= oh_lim;
    assign wrap_kc = cur_kc    >= kw_lim;
    assign wrap_kr = cur_kr    >= kh_lim;
    assign wrap_pl = cur_plane >= ch_lim;

    assign cur_last = wrap_oc && wrap_or && wrap_kc && wrap_kr && wrap_pl;

    // counter chain, output column innermost
    always_comb begin
        ocol_next  = cur_ocol;
        orow_next  = cur_orow;
        kc_next    = cur_kc;
        kr_next    = cur_kr;
        plane_next = cur_plane;
        dst_next   = cur_dst;
        if (cur_last) begin
            ocol_next  = '0;
            orow_next  = '0;
            kc_next    = '0;
            kr_next    = '0;
            plane_next = '0;
            dst_next   = '0;
        end else begin
            if (cur_dst != '1) begin
                dst_next = cur_dst + ADDR_BITS'(1);
            end
            ocol_next = wrap_oc ? '0 : cur_ocol + DIM_BITS'(1);
            if (wrap_oc) begin
                orow_next = wrap_or ? '0 : cur_orow + DIM_BITS'(1);
                if (wrap_or) begin
                    kc_next = wrap_kc ? '0 : cur_kc + 8'd1;
                    if (wrap_kc) begin
                        kr_next = wrap_kr ? '0 : cur_kr + 8'd1;
                        if (wrap_kr) begin
                            plane_next = wrap_pl ? '0 : cur_plane + 12'd1;
                        end
                    end
                end
            end
        end
    end

    // walk state moves only when a word is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_reg <= '0;
            kr_reg    <= '0;
            kc_reg    <= '0;
            orow_reg  <= '0;
            ocol_reg  <= '0;
            dst_reg   <= '0;
        end else if (accept) begin
            plane_reg <= plane_next;
            kr_reg    <= kr_next;
            kc_reg    <= kc_next;
            orow_reg  <= orow_next;
            ocol_reg  <= ocol_next;
            dst_reg   <= dst_next;
        end
    end

    `IAW_ASSERT(a_wrap_after_last, accept && cur_last |=> (plane_reg == '0) && (kr_reg == '0) && (kc_reg == '0) && (orow_reg == '0) && (ocol_reg == '0) && (dst_reg == '0), "walk did not wrap after last element")
    `IAW_ASSERT(a_hold_when_idle, !accept |=> $stable(dst_reg) && $stable(ocol_reg) && $stable(plane_reg), "walk state moved without a word")

endmodule

/* hdl/im2col_address_walker.sv */
// An accepted input word passes through stages 1 to 4 before its result shows on m_tvalid.
// Throughput: one word per cycle; the four-stage address pipeline holds
// only under back-pressure, and a stage frees as soon as the next one moves.
// Reset (aresetn low, synchronous) empties the pipeline, returns the walk to
// its first element and loads the register reset values.
`include "im2col_address_walker_macros.svh"

module im2col_address_walker
    import im2col_pkg::*;
#(
    parameter int ADDR_BITS = 24,
    parameter int DIM_BITS  = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_wdata,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [0] restart
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata,   // [23:0] src_addr, [47:24] dst_addr
    output logic [0:0]           m_tuser,   // [0] is_pad
    output logic                 m_tlast
);

    localparam int PY  = DIM_BITS + 8;          // output position times stride
    localparam int SGW = DIM_BITS + 10;         // signed image coordinate
    localparam int PP  = DIM_BITS + 12;         // plane row base
    localparam int PM  = PP + DIM_BITS;         // row times width
    localparam int SUMW = ((PM + 1 > ADDR_BITS) ? PM + 1 : ADDR_BITS) + 1;
    localparam int AX  = (ADDR_BITS > OUT_ADDR_W) ? ADDR_BITS : OUT_ADDR_W;
    localparam logic [SUMW-1:0] ADDR_MAX_W =
        {{(SUMW - ADDR_BITS){1'b0}}, {ADDR_BITS{1'b1}}};

    // configuration registers
    logic [15:0] kernel_size_reg, stride_reg, padding_reg;
    logic [31:0] input_size_reg, output_size_reg;
    logic [11:0] in_channels_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_size_reg <= KERNEL_SIZE_RST;
            stride_reg      <= STRIDE_RST;
            padding_reg     <= '0;
            input_size_reg  <= '0;
            output_size_reg <= '0;
            in_channels_reg <= IN_CHANNELS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_KERNEL_SIZE: kernel_size_reg <= cfg_wdata[15:0];
                REG_STRIDE:      stride_reg      <= cfg_wdata[15:0];
                REG_PADDING:     padding_reg     <= cfg_wdata[15:0];
                REG_INPUT_SIZE:  input_size_reg  <= cfg_wdata;
                REG_OUTPUT_SIZE: output_size_reg <= cfg_wdata;
                REG_IN_CHANNELS: in_channels_reg <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    kern_cfg_t           kcfg;
    logic [DIM_BITS-1:0] in_w, in_h, out_w, out_h;

    assign kcfg.kw       = kernel_size_reg[7:0];
    assign kcfg.kh       = kernel_size_reg[15:8];
    assign kcfg.sw       = stride_reg[7:0];
    assign kcfg.sv       = stride_reg[15:8];
    assign kcfg.pw       = padding_reg[7:0];
    assign kcfg.pv       = padding_reg[15:8];
    assign kcfg.channels = in_channels_reg;
    assign in_w  = input_size_reg[DIM_BITS-1:0];
    assign in_h  = input_size_reg[16 +: DIM_BITS];
    assign out_w = output_size_reg[DIM_BITS-1:0];
    assign out_h = output_size_reg[16 +: DIM_BITS];

    // stage handshake: a stage loads when it is empty or its word moves on
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic r1, r2, r3, r4;
    logic accept;

    assign r4       = !v4_reg || m_tready;
    assign r3       = !v3_reg || r4;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign s_tready = r1;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (r1) v1_reg <= s_tvalid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
        end
    end

    // element walk
    logic [11:0]          cur_plane;
    logic [7:0]           cur_kr, cur_kc;
    logic [DIM_BITS-1:0]  cur_orow, cur_ocol;
    logic [ADDR_BITS-1:0] cur_dst;
    logic                 cur_last;

    im2col_walk #(
        .ADDR_BITS (ADDR_BITS),
        .DIM_BITS  (DIM_BITS)
    ) u_walk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .restart   (s_tdata[0]),
        .kcfg      (kcfg),
        .out_w     (out_w),
        .out_h     (out_h),
        .cur_plane (cur_plane),
        .cur_kr    (cur_kr),
        .cur_kc    (cur_kc),
        .cur_orow  (cur_orow),
        .cur_ocol  (cur_ocol),
        .cur_dst   (cur_dst),
        .cur_last  (cur_last)
    );

    // stage 1: stride and plane products
    logic [PY-1:0]        s1_prod_y_reg, s1_prod_x_reg;
    logic [PP-1:0]        s1_prod_p_reg;
    logic [7:0]           s1_kr_reg, s1_kc_reg;
    logic [ADDR_BITS-1:0] s1_dst_reg;
    logic                 s1_last_reg;

    always_ff @(posedge aclk) begin
        if (r1 && s_tvalid) begin
            s1_prod_y_reg <= PY'(cur_orow) * PY'(kcfg.sv);
            s1_prod_x_reg <= PY'(cur_ocol) * PY'(kcfg.sw);
            s1_prod_p_reg <= PP'(cur_plane) * PP'(in_h);
            s1_kr_reg     <= cur_kr;
            s1_kc_reg     <= cur_kc;
            s1_dst_reg    <= cur_dst;
            s1_last_reg   <= cur_last;
        end
    end

    // stage 2: image coordinates, bounds check, row base
    logic [SGW-1:0]       iy, ix;
    logic                 pad_c;
    logic [PP-1:0]        s2_row_reg;
    logic [DIM_BITS-1:0]  s2_ix_reg;
    logic                 s2_pad_reg;
    logic [ADDR_BITS-1:0] s2_dst_reg;
    logic                 s2_last_reg;

    assign iy = SGW'(s1_prod_y_reg) + SGW'(s1_kr_reg) - SGW'(kcfg.pv);
    assign ix = SGW'(s1_prod_x_reg) + SGW'(s1_kc_reg) - SGW'(kcfg.pw);
    // negative coordinates show as a set sign bit
    assign pad_c = iy[SGW-1] || ix[SGW-1] || (iy >= SGW'(in_h)) || (ix >= SGW'(in_w));

    always_ff @(posedge aclk) begin
        if (r2 && v1_reg) begin
            s2_row_reg  <= s1_prod_p_reg + PP'(iy[DIM_BITS-1:0]);
            s2_ix_reg   <= ix[DIM_BITS-1:0];
            s2_pad_reg  <= pad_c;
            s2_dst_reg  <= s1_dst_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    // stage 3: row times image width
    logic [PM-1:0]        s3_prod_reg;
    logic [DIM_BITS-1:0]  s3_ix_reg;
    logic                 s3_pad_reg;
    logic [ADDR_BITS-1:0] s3_dst_reg;
    logic                 s3_last_reg;

    always_ff @(posedge aclk) begin
        if (r3 && v2_reg) begin
            s3_prod_reg <= PM'(s2_row_reg) * PM'(in_w);
            s3_ix_reg   <= s2_ix_reg;
            s3_pad_reg  <= s2_pad_reg;
            s3_dst_reg  <= s2_dst_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    // stage 4: add column, zero padded words, saturate, output register
    logic [SUMW-1:0]      src_sum;
    logic [ADDR_BITS-1:0] src_a;
    logic [AX-1:0]        src_x, dst_x;
    logic [OUT_ADDR_W-1:0] m_src_reg, m_dst_reg;
    logic                 m_pad_reg, m_last_reg;

    assign src_sum = SUMW'(s3_prod_reg) + SUMW'(s3_ix_reg);

    always_comb begin
        if (s3_pad_reg) begin
            src_a = '0;
        end else if (src_sum > ADDR_MAX_W) begin
            src_a = '1;
        end else begin
            src_a = src_sum[ADDR_BITS-1:0];
        end
    end

    assign src_x = AX'(src_a);
    assign dst_x = AX'(s3_dst_reg);

    always_ff @(posedge aclk) begin
        if (r4 && v3_reg) begin
            m_src_reg  <= src_x[OUT_ADDR_W-1:0];
            m_dst_reg  <= dst_x[OUT_ADDR_W-1:0];
            m_pad_reg  <= s3_pad_reg;
            m_last_reg <= s3_last_reg;
        end
    end

    assign m_tvalid   = v4_reg;
    assign m_tdata    = {m_dst_reg, m_src_reg};
    assign m_tuser[0] = m_pad_reg;
    assign m_tlast    = m_last_reg;

    `IAW_ASSERT(a_pad_zero_src, m_tvalid && m_tuser[0] |-> m_tdata[23:0] == 24'd0, "padded word carries a source address")
    `IAW_ASSERT(a_ready_when_drained, m_tready |-> s_tready, "pipeline stalled with output free")

endmodule
